// ----- src/blpd_pkg.sv -----
// ============================================================================
// blpd_pkg
// Shared types and codes for the bounded list with positional delete.
// ============================================================================
package blpd_pkg;

    localparam int ACTION_W = 3;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 8;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 5;
    // element index carried between modules; wide enough for lists of up to 256 elements
    localparam int IDX_W    = 8;
    localparam int KIND_W   = 3;

    // request actions
    localparam logic [ACTION_W-1:0] ACT_APPEND     = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_FRONT      = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_DELETE_POS = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_DELETE_MID = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_DELETE_END = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_READ       = 3'd5;

    // response status
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd3;

    // storage operations
    localparam logic [KIND_W-1:0] OP_NONE   = 3'd0;
    localparam logic [KIND_W-1:0] OP_APPEND = 3'd1;
    localparam logic [KIND_W-1:0] OP_FRONT  = 3'd2;
    localparam logic [KIND_W-1:0] OP_REMOVE = 3'd3;
    localparam logic [KIND_W-1:0] OP_POP    = 3'd4;

    typedef struct packed {
        logic [ACTION_W-1:0]      action;
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0]         position;
        logic                     from_tail;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [DATA_W-1:0] read_data;
        logic [LEN_W-1:0]         length;
    } rsp_t;

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic [IDX_W-1:0]         index;
        logic signed [DATA_W-1:0] value;
        logic                     rd_en;
        logic [STATUS_W-1:0]      status;
    } op_t;

endpackage

// ----- src/blpd_decode.sv -----
// ============================================================================
// blpd_decode
// Checks a request against the current length and turns it into a storage op.
// ============================================================================
module blpd_decode #(
    parameter int CAPACITY = 16
) (
    input  blpd_pkg::req_t                      req,
    input  logic [$clog2(CAPACITY+1)-1:0]       count,
    output blpd_pkg::op_t                       op
);

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > blpd_pkg::POS_W) ? CW : blpd_pkg::POS_W;
    localparam int IXW  = blpd_pkg::IDX_W;

    logic            empty;
    logic            full;
    logic            bad_pos;
    logic [CMPW-1:0] pos_w;
    logic [CMPW-1:0] cnt_w;
    logic [CMPW-1:0] rd_addr;
    logic [CW:0]     mid_pos;

    always_comb
    begin
        pos_w   = CMPW'(req.position);
        cnt_w   = CMPW'(count);
        empty   = (count == '0);
        full    = (count == CW'(CAPACITY));
        bad_pos = (pos_w == '0) || (pos_w > cnt_w);
        rd_addr = req.from_tail ? (cnt_w - pos_w) : (pos_w - CMPW'(1));
        // middle sits at (length+1)/2, 1-based
        mid_pos = ({1'b0, count} + (CW+1)'(1)) >> 1;

        op        = '0;
        op.value  = req.value;
        op.kind   = blpd_pkg::OP_NONE;
        op.status = blpd_pkg::ST_OK;

        unique case (req.action)
            blpd_pkg::ACT_APPEND:
            begin
                if (full)
                    op.status = blpd_pkg::ST_FULL;
                else
                begin
                    op.kind  = blpd_pkg::OP_APPEND;
                    op.index = IXW'(count);
                end
            end
            blpd_pkg::ACT_FRONT:
            begin
                if (full)
                    op.status = blpd_pkg::ST_FULL;
                else
                    op.kind = blpd_pkg::OP_FRONT;
            end
            blpd_pkg::ACT_DELETE_POS:
            begin
                if (empty)
                    op.status = blpd_pkg::ST_EMPTY;
                else if (bad_pos)
                    op.status = blpd_pkg::ST_BADPOS;
                else
                begin
                    op.kind  = blpd_pkg::OP_REMOVE;
                    op.index = IXW'(pos_w - CMPW'(1));
                end
            end
            blpd_pkg::ACT_DELETE_MID:
            begin
                if (empty)
                    op.status = blpd_pkg::ST_EMPTY;
                else
                begin
                    op.kind  = blpd_pkg::OP_REMOVE;
                    op.index = IXW'(mid_pos - (CW+1)'(1));
                end
            end
            blpd_pkg::ACT_DELETE_END:
            begin
                if (empty)
                    op.status = blpd_pkg::ST_EMPTY;
                else
                    op.kind = blpd_pkg::OP_POP;
            end
            blpd_pkg::ACT_READ:
            begin
                if (empty)
                    op.status = blpd_pkg::ST_EMPTY;
                else if (bad_pos)
                    op.status = blpd_pkg::ST_BADPOS;
                else
                begin
                    op.rd_en = 1'b1;
                    op.index = IXW'(rd_addr);
                end
            end
            default:
            begin
                // unused codes: no change, status ok
                op.kind = blpd_pkg::OP_NONE;
            end
        endcase
    end

endmodule

// ----- src/blpd_store.sv -----
// ============================================================================
// blpd_store
// Row of element cells and the length counter; all cells shift at once.
// ============================================================================
module blpd_store #(
    parameter int CAPACITY = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  blpd_pkg::op_t                       op,
    output logic [$clog2(CAPACITY+1)-1:0]       count,
    output logic [$clog2(CAPACITY+1)-1:0]       count_after,
    output logic signed [blpd_pkg::DATA_W-1:0]  rdata
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);

    logic signed [blpd_pkg::DATA_W-1:0] cell_reg  [CAPACITY];
    logic signed [blpd_pkg::DATA_W-1:0] cell_next [CAPACITY];
    logic [CW-1:0]                      count_reg;
    logic [CW-1:0]                      count_next;
    logic [IW-1:0]                      idx;

    assign idx         = op.index[IW-1:0];
    assign count       = count_reg;
    assign count_after = count_next;
    assign rdata       = cell_reg[idx];

    always_comb
    begin
        cell_next  = cell_reg;
        count_next = count_reg;
        unique case (op.kind)
            blpd_pkg::OP_APPEND:
            begin
                for (int i = 0; i < CAPACITY; i++)
                begin
                    if (IW'(i) == idx)
                        cell_next[i] = op.value;
                end
                count_next = count_reg + CW'(1);
            end
            blpd_pkg::OP_FRONT:
            begin
                cell_next[0] = op.value;
                for (int i = 1; i < CAPACITY; i++)
                    cell_next[i] = cell_reg[i-1];
                count_next = count_reg + CW'(1);
            end
            blpd_pkg::OP_REMOVE:
            begin
                for (int i = 0; i < CAPACITY - 1; i++)
                begin
                    if (IW'(i) >= idx)
                        cell_next[i] = cell_reg[i+1];
                end
                count_next = count_reg - CW'(1);
            end
            blpd_pkg::OP_POP:
            begin
                count_next = count_reg - CW'(1);
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    // element data: no reset, only entries below the count are read
    always_ff @(posedge clk)
    begin
        if (en)
            cell_reg <= cell_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (en)
            count_reg <= count_next;
    end

endmodule

// ----- src/bounded_list_positional_delete.sv -----
// ============================================================================
// bounded_list_positional_delete
// Ordered list of up to CAPACITY signed words; each edit updates all cells at once.
// ============================================================================
// One request transaction is accepted per clock when the response side does
// not stall, and each produces exactly one response transaction. A request
// lands in an input register; from there a short decode checks it against
// the current length and a row of element cells shifts all entries at once
// (insert at front, delete at a position or the middle) while the length
// counter moves by one. Without response stalls the throughput is one
// request per cycle regardless of the action. Status reports ok, invalid
// position, full, or empty; an empty list is reported before a bad
// position. Action codes 6 and 7 change nothing and report ok. read_data
// is zero except on a successful read. length is the element count after
// the request, shown in 5 bits. Element cells carry no reset; only entries
// below the count are ever read. A stalled response holds in its register
// while one more request may wait in the input register.
module bounded_list_positional_delete #(
    parameter int CAPACITY = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  blpd_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output blpd_pkg::rsp_t rsp
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int LW = blpd_pkg::LEN_W;

    // input register
    logic           in_valid_reg;
    logic           in_valid_next;
    blpd_pkg::req_t in_reg;

    // result register
    logic           rsp_valid_reg;
    logic           rsp_valid_next;
    blpd_pkg::rsp_t rsp_reg;
    blpd_pkg::rsp_t rsp_next;

    logic                               accept;
    logic                               fire;
    blpd_pkg::op_t                      op;
    logic [CW-1:0]                      count;
    logic [CW-1:0]                      count_after;
    logic signed [blpd_pkg::DATA_W-1:0] rdata;

    // the held request moves on whenever the result register is free or drains
    assign fire      = in_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = in_valid_reg && !fire;
    assign accept    = req_valid && !req_stall;

    assign in_valid_next  = accept || (in_valid_reg && !fire);
    assign rsp_valid_next = fire || (rsp_valid_reg && rsp_stall);

    blpd_decode #(
        .CAPACITY (CAPACITY)
    ) u_decode (
        .req   (in_reg),
        .count (count),
        .op    (op)
    );

    blpd_store #(
        .CAPACITY (CAPACITY)
    ) u_store (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (fire),
        .op          (op),
        .count       (count),
        .count_after (count_after),
        .rdata       (rdata)
    );

    always_comb
    begin
        rsp_next.status    = op.status;
        rsp_next.read_data = op.rd_en ? rdata : '0;
        rsp_next.length    = LW'(count_after);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_reg <= req;
        if (fire)
            rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ----- src/blpd_checker.sv -----
// ============================================================================
// blpd_checker
// Port-level checks on response transactions of the bounded list.
// ============================================================================
module blpd_checker #(
    parameter int CAPACITY = 16
) (
    input logic           clk,
    input logic           rst_n,
    input logic           rsp_valid,
    input logic           rsp_stall,
    input blpd_pkg::rsp_t rsp
);

    localparam int LW = blpd_pkg::LEN_W;

    // a stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    // full is reported only when the list holds CAPACITY elements
    a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == blpd_pkg::ST_FULL) |-> rsp.length == LW'(CAPACITY))
        else $error("full status with wrong length");

    // empty is reported only on an empty list
    a_empty_len: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == blpd_pkg::ST_EMPTY) |-> rsp.length == '0)
        else $error("empty status with nonzero length");

    // read data is nonzero only on a successful request
    a_data_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.read_data != '0) |-> rsp.status == blpd_pkg::ST_OK)
        else $error("read data on a failed request");

endmodule

bind bounded_list_positional_delete blpd_checker #(
    .CAPACITY (CAPACITY)
) u_blpd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
